// File: design/tls_client_hello_preread_macros.svh
// Assertion macros shared by the ClientHello pre-reader RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef TLS_CLIENT_HELLO_PREREAD_MACROS_SVH
`define TLS_CLIENT_HELLO_PREREAD_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TLSCH_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("tlsch: check failed");

// Next-cycle implication, checked outside reset.
`define TLSCH_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("tlsch: check failed");

`endif

// File: design/tlsch_pkg.sv
// Package of the ClientHello pre-reader: request/result types, parser state
// and the field walker step function. No dependencies.
package tlsch_pkg;

  // Status codes.
  localparam logic [2:0] ST_NEED     = 3'd0;
  localparam logic [2:0] ST_ACCEPT   = 3'd1;
  localparam logic [2:0] ST_NOT_HS   = 3'd2;
  localparam logic [2:0] ST_BAD_VER  = 3'd3;
  localparam logic [2:0] ST_NOT_CH   = 3'd4;
  localparam logic [2:0] ST_SNI_ERR  = 3'd5;
  localparam logic [2:0] ST_ALPN_ERR = 3'd6;
  localparam logic [2:0] ST_LEN_ERR  = 3'd7;

  localparam logic [7:0] REC_HANDSHAKE = 8'h16;
  localparam logic [7:0] SSL2_FLAG     = 8'h80;
  localparam logic [7:0] COMMA_CHAR    = 8'h2C;
  localparam logic [15:0] EXT_SNI      = 16'd0;
  localparam logic [15:0] EXT_ALPN     = 16'd16;
  localparam logic [15:0] EXT_SUPVER   = 16'd43;
  localparam logic [15:0] RANDOM_LEN   = 16'd32;

  typedef enum logic [4:0] {
    H_START, H_MSGHDR, H_CLIVER, H_RANDOM, H_SIDLEN, H_SID, H_CSLEN, H_CS,
    H_CMLEN, H_CM, H_EXT, H_EXTHDR, H_SNILEN, H_SNIHEAD, H_SNIHOST,
    H_ALPNLEN, H_PLEN, H_PDATA, H_SVLEN
  } hello_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       start_of_stream;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] version_major;
    logic [7:0] version_minor;
    logic       name_valid;
    logic       name_kind;
    logic [7:0] name_byte;
  } res_t;

  // Field walker state plus the decision of the last walker step.
  typedef struct packed {
    hello_e          hs;
    logic [15:0]     fr;
    logic [23:0]     hl;
    logic [15:0]     el;
    logic [3:0][7:0] fb;
    logic [1:0][7:0] vb;
    logic            sni;
    logic            alpn;
    logic            comma;
    logic [2:0]      dec;
  } walk_t;

  // Complete parser state.
  typedef struct packed {
    logic [4:0][7:0] rh;
    logic [2:0]      hc;
    logic [15:0]     rr;
    walk_t           w;
    logic [2:0]      decision;
  } st_t;

  localparam st_t ST_RESET = '{rh: '0, hc: '0, rr: '0,
    w: '{hs: H_START, fr: '0, hl: '0, el: '0, fb: '0, vb: '0,
         sni: 1'b0, alpn: 1'b0, comma: 1'b0, dec: ST_NEED},
    decision: ST_NEED};

  // One walker transition, taken when the current field is complete.
  function automatic walk_t walk_adv(walk_t w);
    walk_t       r;
    logic [15:0] sz;
    logic [16:0] need;
    logic [15:0] t;
    r    = w;
    sz   = '0;
    need = '0;
    t    = {w.fb[0], w.fb[1]};
    r.dec = ST_NEED;
    case (w.hs)
      H_START: begin
        r.hs = H_MSGHDR; sz = 16'd4; r.hl = 24'd4;
      end
      H_MSGHDR: begin
        if (w.fb[0] != 8'd1) begin
          r.dec = ST_NOT_CH;
        end else begin
          r.hs = H_CLIVER; sz = 16'd2; r.hl = {w.fb[1], w.fb[2], w.fb[3]};
        end
      end
      H_CLIVER: begin r.hs = H_RANDOM; sz = RANDOM_LEN; end
      H_RANDOM: begin r.hs = H_SIDLEN; sz = 16'd1; end
      H_SIDLEN: begin r.hs = H_SID; sz = {8'd0, w.fb[3]}; end
      H_SID:    begin r.hs = H_CSLEN; sz = 16'd2; end
      H_CSLEN:  begin r.hs = H_CS; sz = {w.fb[2], w.fb[3]}; end
      H_CS:     begin r.hs = H_CMLEN; sz = 16'd1; end
      H_CMLEN:  begin r.hs = H_CM; sz = {8'd0, w.fb[3]}; end
      H_CM, H_EXT: begin
        if (w.hl == '0) begin
          r.dec = ST_ACCEPT;
        end else if (w.hs == H_CM) begin
          r.hs = H_EXT; sz = 16'd2;
        end else begin
          r.hs = H_EXTHDR; sz = 16'd4;
        end
      end
      H_EXTHDR: begin
        if (t == EXT_SNI && !w.sni) begin
          r.hs = H_SNILEN; sz = 16'd2;
        end else if (t == EXT_ALPN && !w.alpn) begin
          r.hs = H_ALPNLEN; sz = 16'd2;
        end else if (t == EXT_SUPVER) begin
          r.hs = H_SVLEN; sz = 16'd1;
        end else begin
          r.hs = H_EXT; sz = {w.fb[2], w.fb[3]};
        end
      end
      H_SNILEN: begin
        r.el = {w.fb[2], w.fb[3]}; r.hs = H_SNIHEAD; sz = 16'd3;
      end
      H_SNIHEAD: begin
        sz   = {w.fb[2], w.fb[3]};
        need = {1'b0, sz} + 17'd3;
        if (w.fb[1] != 8'd0 || {1'b0, w.el} < need) begin
          r.dec = ST_SNI_ERR;
        end else begin
          r.el  = w.el - need[15:0];
          r.sni = 1'b1;
          r.hs  = H_SNIHOST;
        end
      end
      H_SNIHOST: begin r.hs = H_EXT; sz = w.el; end
      H_ALPNLEN: begin
        r.el = {w.fb[2], w.fb[3]}; r.alpn = 1'b1; r.hs = H_PLEN; sz = 16'd1;
      end
      H_PLEN: begin
        sz   = {8'd0, w.fb[3]};
        need = {1'b0, sz} + 17'd1;
        if (sz == '0 || {1'b0, w.el} < need) begin
          r.dec = ST_ALPN_ERR;
        end else begin
          r.el = w.el - need[15:0];
          r.hs = H_PDATA;
        end
      end
      H_PDATA: begin
        if (w.el != '0) begin
          r.comma = 1'b1; r.hs = H_PLEN; sz = 16'd1;
        end else begin
          r.hs = H_EXT; sz = '0;
        end
      end
      H_SVLEN: begin
        r.vb[0] = 8'd3; r.vb[1] = 8'd4; r.hs = H_EXT; sz = {8'd0, w.fb[3]};
      end
      default: r.dec = ST_LEN_ERR;
    endcase
    // Length check against what is left of the handshake message.
    if (r.dec == ST_NEED) begin
      r.fr = sz;
      if (r.hl < {8'd0, sz}) r.dec = ST_LEN_ERR;
    end
    return r;
  endfunction

endpackage

// File: design/tlsch_step.sv
// Next-state and result logic of the pre-reader for one byte.
// Depends on tlsch_pkg.
module tlsch_step (
  input  tlsch_pkg::st_t  cur_i,
  input  tlsch_pkg::req_t req_i,
  output tlsch_pkg::st_t  nxt_o,
  output tlsch_pkg::res_t res_o
);
  import tlsch_pkg::*;

  localparam int unsigned SettleSteps = 4;

  st_t        s;
  walk_t      w;
  logic [7:0] b;
  logic       nv, nk;
  logic [7:0] nb;

  always_comb begin
    b  = req_i.stream_byte;
    s  = req_i.start_of_stream ? ST_RESET : cur_i;
    nv = 1'b0;
    nk = 1'b0;
    nb = '0;
    w  = s.w;
    // A comma owed from the previous protocol name goes out first.
    if (s.w.comma) begin
      s.w.comma = 1'b0;
      nv = 1'b1; nk = 1'b1; nb = COMMA_CHAR;
    end
    if (s.decision == ST_NEED) begin
      if (s.hc < 3'd5) begin
        // Collect the record header.
        case (s.hc)
          3'd0:    s.rh[0] = b;
          3'd1:    s.rh[1] = b;
          3'd2:    s.rh[2] = b;
          3'd3:    s.rh[3] = b;
          default: s.rh[4] = b;
        endcase
        s.hc = s.hc + 3'd1;
        if (s.hc == 3'd5) begin
          if ((s.rh[0] & SSL2_FLAG) != '0 && s.rh[2] == 8'd1 &&
              (s.rh[3] == 8'd0 || s.rh[3] == 8'd3)) begin
            s.w.vb[0] = s.rh[3];
            s.w.vb[1] = s.rh[4];
            s.decision = ST_ACCEPT;
          end else if (s.rh[0] != REC_HANDSHAKE) begin
            s.decision = ST_NOT_HS;
          end else if (s.rh[1] != 8'd3) begin
            s.decision = ST_BAD_VER;
          end else begin
            s.rr = {s.rh[3], s.rh[4]};
            if (s.rr == '0) s.hc = '0;
          end
        end
      end else begin
        // Record payload byte.
        if (s.rr != '0) s.rr = s.rr - 16'd1;
        if (s.rr == '0) s.hc = '0;
        w = s.w;
        w.dec = ST_NEED;
        // Only the start state enters with no field open.
        if (w.fr == '0) w = walk_adv(w);
        if (w.dec == ST_NEED) begin
          w.fr = w.fr - 16'd1;
          if (w.hl != '0) w.hl = w.hl - 24'd1;
          case (w.hs)
            H_CLIVER: begin
              w.vb[0] = w.vb[1];
              w.vb[1] = b;
            end
            H_SNIHOST: begin nv = 1'b1; nk = 1'b0; nb = b; end
            H_PDATA:   begin nv = 1'b1; nk = 1'b1; nb = b; end
            default:   w.fb = {b, w.fb[3:1]};
          endcase
          // Resolve empty fields that follow this byte.
          for (int unsigned i = 0; i < SettleSteps; i++) begin
            if (w.dec == ST_NEED && w.fr == '0) w = walk_adv(w);
          end
        end
        s.decision = w.dec;
        s.w = w;
        s.w.dec = ST_NEED;
      end
    end
    nxt_o = s;
    res_o.status        = s.decision;
    res_o.version_major = s.w.vb[0];
    res_o.version_minor = s.w.vb[1];
    res_o.name_valid    = nv;
    res_o.name_kind     = nk;
    res_o.name_byte     = nb;
  end

endmodule

// File: design/tls_client_hello_preread.sv
// TLS ClientHello pre-reader: one status result per stream byte, taking one
// byte every clock cycle while the output is not stalled. A request passes an
// input register, then combinational parser logic updates the state and loads
// the result register. The field walker is combinational and resolves up to
// four empty fields in the same cycle as the byte. Assert start_of_stream on
// the first byte of a connection; the decision stays until the next start.
module tls_client_hello_preread (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tlsch_pkg::req_t  in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tlsch_pkg::res_t  out_res_o
);
  import tlsch_pkg::*;
  `include "tls_client_hello_preread_macros.svh"

  logic s1_valid_q;
  req_t s1_req_q;
  logic out_valid_q;
  res_t out_res_q;
  st_t  st_q, st_d;
  res_t res_d;
  logic fire;

  assign fire        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || fire;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  tlsch_step u_step (
    .cur_i (st_q),
    .req_i (s1_req_q),
    .nxt_o (st_d),
    .res_o (res_d)
  );

  // Control state and parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= ST_RESET;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (fire) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) s1_req_q <= in_req_i;
    if (fire) out_res_q <= res_d;
  end

  `TLSCH_ASSERT_NOW(a_ready_when_empty, !s1_valid_q, in_ready_o)
  `TLSCH_ASSERT_NOW(a_name_idle_zero, out_valid_q && !out_res_q.name_valid,
    !out_res_q.name_kind && out_res_q.name_byte == '0)
  `TLSCH_ASSERT_NEXT(a_decision_sticky,
    fire && !s1_req_q.start_of_stream && st_q.decision != ST_NEED,
    st_q.decision == $past(st_q.decision))
  `TLSCH_ASSERT_NEXT(a_status_tracks_state, fire, out_res_q.status == st_q.decision)

endmodule
